// ===== rtl/core/pickle_opcode_tokenizer_top_defines.svh =====
// ---------------------------------------------------------------------------
// Pickle opcode tokenizer assertion macros
// Concurrent check helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef PICKLE_OPCODE_TOKENIZER_TOP_DEFINES_SVH
`define PICKLE_OPCODE_TOKENIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define POT_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pot assertion failed");

// consequent must hold in the cycle after the antecedent
`define POT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pot assertion failed");

`else

`define POT_ASSERT_ALWAYS(label, clk, rst, prop)
`define POT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/pot_pkg.sv =====
// ---------------------------------------------------------------------------
// Pickle opcode tokenizer package
// Shared types and constants for the front, queue and back.
// ---------------------------------------------------------------------------
package pot_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] BYTE_MARKER  = 8'h80;
   localparam logic [7:0] BYTE_FRAME   = 8'h95;
   localparam logic [7:0] BYTE_MEMO    = 8'h94;
   localparam logic [7:0] BYTE_STR1    = 8'h8C;
   localparam logic [7:0] BYTE_STR4    = 8'h58;  // 'X'
   localparam logic [7:0] BYTE_SHORT   = 8'h4D;  // 'M'
   localparam logic [7:0] BYTE_GLOBAL  = 8'h63;  // 'c'
   localparam logic [7:0] BYTE_STOP    = 8'h2E;  // '.'
   localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
   localparam logic [7:0] BYTE_DICT    = 8'h7D;  // '}'
   localparam logic [7:0] BYTE_LIST    = 8'h5D;  // ']'
   localparam logic [7:0] BYTE_MARK    = 8'h28;  // '('
   localparam logic [7:0] BYTE_TUPLE   = 8'h74;  // 't'
   localparam logic [7:0] BYTE_OP_H    = 8'h68;  // 'h'
   localparam logic [7:0] BYTE_OP_Q    = 8'h71;  // 'q'

   localparam logic [31:0] FRAME_LEN   = 32'd8;
   localparam logic [15:0] VALUE_SAT   = 16'hFFFF;

   typedef enum logic [3:0] {
      OP_OTHER,
      OP_DICT,
      OP_LIST,
      OP_MARK,
      OP_TUPLE,
      OP_MEMO,
      OP_STOP,
      OP_BYTEOP,
      OP_FRAME,
      OP_SHORT,
      OP_STR4,
      OP_STR1,
      OP_GLOBAL
   } op_class_type;

   typedef enum logic [3:0] {
      EV_PROTO,
      EV_DICT,
      EV_LIST,
      EV_BYTE,
      EV_MEMO,
      EV_SHORT,
      EV_MARK,
      EV_STRBEGIN,
      EV_STRCHAR,
      EV_MODCHAR,
      EV_NAMECHAR,
      EV_MODEND,
      EV_NAMEEND,
      EV_TUPLE,
      EV_STOP,
      EV_ERROR
   } ev_kind_type;

   typedef enum logic [3:0] {
      PH_MARKER,
      PH_PROTO,
      PH_OPCODE,
      PH_BYTEOP,
      PH_SKIP,
      PH_SHORTLO,
      PH_SHORTHI,
      PH_LEN4,
      PH_LEN1,
      PH_CHARS,
      PH_MODULE,
      PH_NAME,
      PH_HALT
   } phase_type;

   // one classified stream byte
   typedef struct packed {
      logic [7:0]   data;
      op_class_type op;
      logic         is_marker;
      logic         is_newline;
   } token_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
      logic              empty;
   } q_status_type;

   typedef struct packed {
      logic halted;
   } back_status_type;

endpackage

// ===== rtl/core/pot_front.sv =====
// ---------------------------------------------------------------------------
// Pickle tokenizer front stage
// Registers each accepted byte with its opcode class and hands it on.
// ---------------------------------------------------------------------------
module pot_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_stream_byte,
   input  pot_pkg::q_status_type q_status,
   output logic                  push,
   output pot_pkg::token_type    push_token
);

   logic               f_valid_ff;
   logic               f_valid_in;
   pot_pkg::token_type tok_ff;
   logic               accept;

   function automatic pot_pkg::op_class_type classify(input logic [7:0] b);
      pot_pkg::op_class_type op;
      op = pot_pkg::OP_OTHER;
      unique case (b)
         pot_pkg::BYTE_DICT:   op = pot_pkg::OP_DICT;
         pot_pkg::BYTE_LIST:   op = pot_pkg::OP_LIST;
         pot_pkg::BYTE_MARK:   op = pot_pkg::OP_MARK;
         pot_pkg::BYTE_TUPLE:  op = pot_pkg::OP_TUPLE;
         pot_pkg::BYTE_MEMO:   op = pot_pkg::OP_MEMO;
         pot_pkg::BYTE_STOP:   op = pot_pkg::OP_STOP;
         pot_pkg::BYTE_OP_H,
         pot_pkg::BYTE_OP_Q:   op = pot_pkg::OP_BYTEOP;
         pot_pkg::BYTE_FRAME:  op = pot_pkg::OP_FRAME;
         pot_pkg::BYTE_SHORT:  op = pot_pkg::OP_SHORT;
         pot_pkg::BYTE_STR4:   op = pot_pkg::OP_STR4;
         pot_pkg::BYTE_STR1:   op = pot_pkg::OP_STR1;
         pot_pkg::BYTE_GLOBAL: op = pot_pkg::OP_GLOBAL;
         default:              op = pot_pkg::OP_OTHER;
      endcase
      return op;
   endfunction

   assign push      = f_valid_ff && !q_status.full;
   assign req_stall = f_valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign push_token = tok_ff;

   always_comb begin
      f_valid_in = f_valid_ff;
      if (accept) begin
         f_valid_in = 1'b1;
      end else if (push) begin
         f_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tok_ff.data       <= req_stream_byte;
         tok_ff.op         <= classify(req_stream_byte);
         tok_ff.is_marker  <= (req_stream_byte == pot_pkg::BYTE_MARKER);
         tok_ff.is_newline <= (req_stream_byte == pot_pkg::BYTE_NEWLINE);
      end
   end

endmodule

// ===== rtl/core/pot_queue.sv =====
// ---------------------------------------------------------------------------
// Pickle tokenizer token queue
// Small FIFO that decouples the front stage from the back stage.
// ---------------------------------------------------------------------------
module pot_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pot_pkg::token_type    push_token,
   input  logic                  pop,
   output pot_pkg::token_type    pop_token,
   output pot_pkg::q_status_type q_status
);

   pot_pkg::token_type              entry_ff [pot_pkg::QUEUE_DEPTH];
   logic [pot_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pot_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pot_pkg::QCNT_W-1:0]      count_ff, count_in;

   // depth is a power of two, so pointers wrap on their own
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

   assign pop_token      = entry_ff[rd_ptr_ff];
   assign q_status.count = count_ff;
   assign q_status.full  = (count_ff == pot_pkg::QCNT_W'(pot_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule

// ===== rtl/core/pot_back.sv =====
// ---------------------------------------------------------------------------
// Pickle tokenizer back stage
// Parse state machine over classified bytes, with the response register.
// ---------------------------------------------------------------------------
module pot_back #(
   parameter int NAME_LIMIT = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pot_pkg::token_type       pop_token,
   input  pot_pkg::q_status_type    q_status,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [3:0]               rsp_event_kind,
   output logic [15:0]              rsp_event_value,
   output logic                     rsp_last_char,
   output pot_pkg::back_status_type back_status
);

   localparam int CNT_W = $clog2(NAME_LIMIT);

   pot_pkg::phase_type   phase_ff, phase_in;
   logic [31:0]          remain_ff, remain_in;
   logic [1:0]           len_idx_ff, len_idx_in;
   logic [7:0]           low_hold_ff, low_hold_in;
   logic [CNT_W-1:0]     name_cnt_ff, name_cnt_in;

   logic                 rsp_valid_ff;
   pot_pkg::ev_kind_type rsp_kind_ff;
   logic [15:0]          rsp_value_ff;
   logic                 rsp_last_ff;

   logic                 ev_fire;
   pot_pkg::ev_kind_type ev_kind;
   logic [15:0]          ev_value;
   logic                 ev_last;
   logic [31:0]          len_full;
   logic [7:0]           b;

   assign pop = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign b   = pop_token.data;

   // little-endian length gather
   assign len_full = remain_ff | ({24'b0, b} << {len_idx_ff, 3'b000});

   always_comb begin
      phase_in    = phase_ff;
      remain_in   = remain_ff;
      len_idx_in  = len_idx_ff;
      low_hold_in = low_hold_ff;
      name_cnt_in = name_cnt_ff;
      ev_fire     = 1'b0;
      ev_kind     = pot_pkg::EV_ERROR;
      ev_value    = '0;
      ev_last     = 1'b0;
      if (pop) begin
         unique case (phase_ff)
            pot_pkg::PH_MARKER: begin
               if (pop_token.is_marker) begin
                  phase_in = pot_pkg::PH_PROTO;
               end else begin
                  phase_in = pot_pkg::PH_HALT;
                  ev_fire  = 1'b1;
               end
            end
            pot_pkg::PH_PROTO: begin
               phase_in = pot_pkg::PH_OPCODE;
               ev_fire  = 1'b1;
               ev_kind  = pot_pkg::EV_PROTO;
               ev_value = {8'b0, b};
            end
            pot_pkg::PH_OPCODE: begin
               unique case (pop_token.op)
                  pot_pkg::OP_DICT:  begin ev_fire = 1'b1; ev_kind = pot_pkg::EV_DICT;  end
                  pot_pkg::OP_LIST:  begin ev_fire = 1'b1; ev_kind = pot_pkg::EV_LIST;  end
                  pot_pkg::OP_MARK:  begin ev_fire = 1'b1; ev_kind = pot_pkg::EV_MARK;  end
                  pot_pkg::OP_TUPLE: begin ev_fire = 1'b1; ev_kind = pot_pkg::EV_TUPLE; end
                  pot_pkg::OP_MEMO:  begin ev_fire = 1'b1; ev_kind = pot_pkg::EV_MEMO;  end
                  pot_pkg::OP_STOP: begin
                     ev_fire  = 1'b1;
                     ev_kind  = pot_pkg::EV_STOP;
                     phase_in = pot_pkg::PH_HALT;
                  end
                  pot_pkg::OP_BYTEOP: phase_in = pot_pkg::PH_BYTEOP;
                  pot_pkg::OP_FRAME: begin
                     remain_in = pot_pkg::FRAME_LEN;
                     phase_in  = pot_pkg::PH_SKIP;
                  end
                  pot_pkg::OP_SHORT: phase_in = pot_pkg::PH_SHORTLO;
                  pot_pkg::OP_STR4: begin
                     remain_in  = '0;
                     len_idx_in = '0;
                     phase_in   = pot_pkg::PH_LEN4;
                  end
                  pot_pkg::OP_STR1: phase_in = pot_pkg::PH_LEN1;
                  pot_pkg::OP_GLOBAL: begin
                     name_cnt_in = '0;
                     phase_in    = pot_pkg::PH_MODULE;
                  end
                  default: ;  // unknown opcode: skipped
               endcase
            end
            pot_pkg::PH_BYTEOP: begin
               phase_in = pot_pkg::PH_OPCODE;
               ev_fire  = 1'b1;
               ev_kind  = pot_pkg::EV_BYTE;
               ev_value = {8'b0, b};
            end
            pot_pkg::PH_SKIP: begin
               remain_in = remain_ff - 32'd1;
               if (remain_ff == 32'd1) begin
                  phase_in = pot_pkg::PH_OPCODE;
               end
            end
            pot_pkg::PH_SHORTLO: begin
               low_hold_in = b;
               phase_in    = pot_pkg::PH_SHORTHI;
            end
            pot_pkg::PH_SHORTHI: begin
               phase_in = pot_pkg::PH_OPCODE;
               ev_fire  = 1'b1;
               ev_kind  = pot_pkg::EV_SHORT;
               ev_value = {b, low_hold_ff};
            end
            pot_pkg::PH_LEN4: begin
               remain_in = len_full;
               if (len_idx_ff == 2'd3) begin
                  len_idx_in = '0;
                  ev_fire    = 1'b1;
                  ev_kind    = pot_pkg::EV_STRBEGIN;
                  ev_value   = (len_full[31:16] != '0) ? pot_pkg::VALUE_SAT : len_full[15:0];
                  phase_in   = (len_full != '0) ? pot_pkg::PH_CHARS : pot_pkg::PH_OPCODE;
               end else begin
                  len_idx_in = len_idx_ff + 2'd1;
               end
            end
            pot_pkg::PH_LEN1: begin
               remain_in = {24'b0, b};
               ev_fire   = 1'b1;
               ev_kind   = pot_pkg::EV_STRBEGIN;
               ev_value  = {8'b0, b};
               phase_in  = (b != '0) ? pot_pkg::PH_CHARS : pot_pkg::PH_OPCODE;
            end
            pot_pkg::PH_CHARS: begin
               ev_fire   = 1'b1;
               ev_kind   = pot_pkg::EV_STRCHAR;
               ev_value  = {8'b0, b};
               ev_last   = (remain_ff <= 32'd1);
               remain_in = (remain_ff == '0) ? '0 : remain_ff - 32'd1;
               if (remain_ff <= 32'd1) begin
                  phase_in = pot_pkg::PH_OPCODE;
               end
            end
            pot_pkg::PH_MODULE,
            pot_pkg::PH_NAME: begin
               ev_fire = 1'b1;
               if (pop_token.is_newline) begin
                  ev_kind     = (phase_ff == pot_pkg::PH_MODULE) ?
                                pot_pkg::EV_MODEND : pot_pkg::EV_NAMEEND;
                  ev_value    = 16'(name_cnt_ff);
                  name_cnt_in = '0;
                  phase_in    = (phase_ff == pot_pkg::PH_MODULE) ?
                                pot_pkg::PH_NAME : pot_pkg::PH_OPCODE;
               end else if (name_cnt_ff == CNT_W'(NAME_LIMIT - 1)) begin
                  ev_kind  = pot_pkg::EV_ERROR;
                  phase_in = pot_pkg::PH_HALT;
               end else begin
                  ev_kind     = (phase_ff == pot_pkg::PH_MODULE) ?
                                pot_pkg::EV_MODCHAR : pot_pkg::EV_NAMECHAR;
                  ev_value    = {8'b0, b};
                  name_cnt_in = name_cnt_ff + 1'b1;
               end
            end
            pot_pkg::PH_HALT: ;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= pot_pkg::PH_MARKER;
         remain_ff   <= '0;
         len_idx_ff  <= '0;
         low_hold_ff <= '0;
         name_cnt_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         remain_ff   <= remain_in;
         len_idx_ff  <= len_idx_in;
         low_hold_ff <= low_hold_in;
         name_cnt_ff <= name_cnt_in;
      end
   end

   // response register: loads only when free or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ev_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_fire) begin
         rsp_kind_ff  <= ev_kind;
         rsp_value_ff <= ev_value;
         rsp_last_ff  <= ev_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = rsp_kind_ff;
   assign rsp_event_value    = rsp_value_ff;
   assign rsp_last_char      = rsp_last_ff;
   assign back_status.halted = (phase_ff == pot_pkg::PH_HALT);

endmodule

// ===== rtl/core/pickle_opcode_tokenizer_top.sv =====
// ---------------------------------------------------------------------------
// Pickle opcode tokenizer
// Turns a pickle byte stream into token events, one byte per clock unless stalled.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one stream byte per transaction (req_valid / req_stall).
//   rsp_* carries one token event per transaction (rsp_valid / rsp_stall):
//   kind, value and a last-character flag on string data.
//   A byte yields zero or one event; opcode prefixes, skipped frame bytes
//   and unknown opcodes yield none.
// Path: an event reaches rsp_* through the front register, then the queue
//   into the parse machine and the response reg.
// Throughput: one byte per cycle sustained while rsp is not stalled; the parse
//   state machine in the back stage retires one byte each cycle that it pops.
// Stall: a stalled rsp holds its event while the 4-entry queue and the
//   front register keep absorbing bytes; req_stall rises only once both
//   are full.
// Reset: synchronous, active high; empties the queue and returns the
//   parser to waiting for the protocol marker. After a stop or an error
//   event, bytes are taken and dropped until the next reset.
// ---------------------------------------------------------------------------
`include "pickle_opcode_tokenizer_top_defines.svh"

module pickle_opcode_tokenizer_top #(
   parameter int NAME_LIMIT = 32   // longest module/name text incl. newline
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_event_kind,
   output logic [15:0] rsp_event_value,
   output logic        rsp_last_char
);

   logic                     push;
   logic                     pop;
   pot_pkg::token_type       push_token;
   pot_pkg::token_type       pop_token;
   pot_pkg::q_status_type    q_status;
   pot_pkg::back_status_type back_status;

   // front: take a byte and classify its opcode
   pot_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .q_status        (q_status),
      .push            (push),
      .push_token      (push_token)
   );

   // queue between the two halves so each can stall alone
   pot_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .pop_token  (pop_token),
      .q_status   (q_status)
   );

   // back: parse state machine and response register
   pot_back #(
      .NAME_LIMIT (NAME_LIMIT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_token       (pop_token),
      .q_status        (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_value (rsp_event_value),
      .rsp_last_char   (rsp_last_char),
      .back_status     (back_status)
   );

   // halted parser stays halted until reset
   `POT_ASSERT_NEXT(a_halt_sticky, clock, reset, back_status.halted, back_status.halted)

   // once halted with no event pending, no new event shows up
   `POT_ASSERT_NEXT(a_halt_silent, clock, reset, back_status.halted && !rsp_valid, !rsp_valid)

   // queue occupancy never runs past its depth
   `POT_ASSERT_ALWAYS(a_queue_bound, clock, reset, q_status.count <= pot_pkg::QCNT_W'(pot_pkg::QUEUE_DEPTH))

endmodule

// ===== sim/tb_pickle_opcode_tokenizer_top.sv =====
// ---------------------------------------------------------------------------
// Pickle opcode tokenizer testbench
// Feeds one pickle byte stream through the tokenizer and checks every token
// event against a cycle-free model of the parser. Directed tests come first,
// then random well-formed opcode sequences with idle and stall bursts, a
// long receiver hold-off, and a tail with no idling that ends either in a
// halting event or partway through a string longer than 16 bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pickle_opcode_tokenizer_top;

   localparam int NAME_LIMIT      = 32;
   localparam int RESET_CYCLES    = 5;
   localparam int WATCHDOG_LIMIT  = 2000;   // cycles with no transaction at all
   localparam int DRAIN_CYCLES    = 16;     // extra drain time after the last expected event
   localparam int HOLD_CYCLES     = 300;    // receiver hold-off length
   localparam int RANDOM_BYTES    = 600;
   localparam int TAIL_BYTES      = 100;
   localparam int LONG_CHARS      = 40;     // chars sent of the long string
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      pot_pkg::ev_kind_type kind;
      logic [15:0]          value;
      logic                 last;
   } tok_event_type;

   // DUT connections; every input is known from time zero
   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [3:0]  rsp_event_kind;
   logic [15:0] rsp_event_value;
   logic        rsp_last_char;

   // idling controls shared by the sender task and the receiver process
   bit idle_on  = 1'b1;
   int hold_len = 0;

   // parser model state
   pot_pkg::phase_type ph;
   logic [31:0]        remain;
   logic [31:0]        len_shift;
   logic [7:0]         low_hold;
   logic [8:0]         name_cnt;

   tok_event_type pending_events[$];
   int            mismatch_count = 0;
   int            bytes_taken    = 0;

   pickle_opcode_tokenizer_top #(
      .NAME_LIMIT(NAME_LIMIT)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_value (rsp_event_value),
      .rsp_last_char   (rsp_last_char)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Parser model
   // -------------------------------------------------------------------------
   task automatic push_event(input pot_pkg::ev_kind_type kind, input logic [15:0] value,
                             input logic last);
      tok_event_type ev;
      ev.kind  = kind;
      ev.value = value;
      ev.last  = last;
      pending_events.push_back(ev);
   endtask

   // string length is complete: announce it (saturated), then pass chars
   task automatic open_string();
      push_event(pot_pkg::EV_STRBEGIN,
                 (remain > 32'h0000_FFFF) ? pot_pkg::VALUE_SAT : remain[15:0], 1'b0);
      ph = (remain != 32'd0) ? pot_pkg::PH_CHARS : pot_pkg::PH_OPCODE;
   endtask

   // one byte of module or name text; the newline may sit at any of the
   // first NAME_LIMIT positions, anything else at the last one is an error
   task automatic take_name_byte(input logic [7:0] b,
                                 input pot_pkg::ev_kind_type char_kind,
                                 input pot_pkg::ev_kind_type end_kind,
                                 input pot_pkg::phase_type next_ph);
      if (b == pot_pkg::BYTE_NEWLINE) begin
         push_event(end_kind, {7'd0, name_cnt}, 1'b0);
         name_cnt = 9'd0;
         ph       = next_ph;
      end else if (name_cnt >= NAME_LIMIT - 1) begin
         ph = pot_pkg::PH_HALT;
         push_event(pot_pkg::EV_ERROR, 16'd0, 1'b0);
      end else begin
         name_cnt = name_cnt + 9'd1;
         push_event(char_kind, {8'd0, b}, 1'b0);
      end
   endtask

   task automatic tokenize_byte(input logic [7:0] b);
      logic last;
      case (ph)
         pot_pkg::PH_MARKER: begin
            if (b == pot_pkg::BYTE_MARKER) begin
               ph = pot_pkg::PH_PROTO;
            end else begin
               ph = pot_pkg::PH_HALT;
               push_event(pot_pkg::EV_ERROR, 16'd0, 1'b0);
            end
         end
         pot_pkg::PH_PROTO: begin
            ph = pot_pkg::PH_OPCODE;
            push_event(pot_pkg::EV_PROTO, {8'd0, b}, 1'b0);
         end
         pot_pkg::PH_OPCODE: begin
            case (b)
               pot_pkg::BYTE_DICT:  push_event(pot_pkg::EV_DICT, 16'd0, 1'b0);
               pot_pkg::BYTE_LIST:  push_event(pot_pkg::EV_LIST, 16'd0, 1'b0);
               pot_pkg::BYTE_MARK:  push_event(pot_pkg::EV_MARK, 16'd0, 1'b0);
               pot_pkg::BYTE_TUPLE: push_event(pot_pkg::EV_TUPLE, 16'd0, 1'b0);
               pot_pkg::BYTE_MEMO:  push_event(pot_pkg::EV_MEMO, 16'd0, 1'b0);
               pot_pkg::BYTE_STOP: begin
                  ph = pot_pkg::PH_HALT;
                  push_event(pot_pkg::EV_STOP, 16'd0, 1'b0);
               end
               pot_pkg::BYTE_OP_H, pot_pkg::BYTE_OP_Q: ph = pot_pkg::PH_BYTEOP;
               pot_pkg::BYTE_FRAME: begin
                  remain = pot_pkg::FRAME_LEN;
                  ph     = pot_pkg::PH_SKIP;
               end
               pot_pkg::BYTE_SHORT: ph = pot_pkg::PH_SHORTLO;
               pot_pkg::BYTE_STR4: begin
                  remain    = 32'd0;
                  len_shift = 32'd0;
                  ph        = pot_pkg::PH_LEN4;
               end
               pot_pkg::BYTE_STR1: ph = pot_pkg::PH_LEN1;
               pot_pkg::BYTE_GLOBAL: begin
                  name_cnt = 9'd0;
                  ph       = pot_pkg::PH_MODULE;
               end
               default: ;   // unknown opcode, skipped
            endcase
         end
         pot_pkg::PH_BYTEOP: begin
            ph = pot_pkg::PH_OPCODE;
            push_event(pot_pkg::EV_BYTE, {8'd0, b}, 1'b0);
         end
         pot_pkg::PH_SKIP: begin
            remain = remain - 32'd1;
            if (remain == 32'd0) ph = pot_pkg::PH_OPCODE;
         end
         pot_pkg::PH_SHORTLO: begin
            low_hold = b;
            ph       = pot_pkg::PH_SHORTHI;
         end
         pot_pkg::PH_SHORTHI: begin
            ph = pot_pkg::PH_OPCODE;
            push_event(pot_pkg::EV_SHORT, {b, low_hold}, 1'b0);
         end
         pot_pkg::PH_LEN4: begin
            remain = remain | ({24'd0, b} << len_shift[4:0]);
            if (len_shift >= 32'd24) begin
               len_shift = 32'd0;
               open_string();
            end else begin
               len_shift = len_shift + 32'd8;
            end
         end
         pot_pkg::PH_LEN1: begin
            remain = {24'd0, b};
            open_string();
         end
         pot_pkg::PH_CHARS: begin
            last   = (remain <= 32'd1);
            remain = (remain == 32'd0) ? 32'd0 : remain - 32'd1;
            if (remain == 32'd0) ph = pot_pkg::PH_OPCODE;
            push_event(pot_pkg::EV_STRCHAR, {8'd0, b}, last);
         end
         pot_pkg::PH_MODULE:
            take_name_byte(b, pot_pkg::EV_MODCHAR, pot_pkg::EV_MODEND, pot_pkg::PH_NAME);
         pot_pkg::PH_NAME:
            take_name_byte(b, pot_pkg::EV_NAMECHAR, pot_pkg::EV_NAMEEND, pot_pkg::PH_OPCODE);
         default: ;   // halted
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Sender: one stream byte per transaction. An optional idle burst comes
   // first; valid then stays high with a stable byte until it is taken.
   // -------------------------------------------------------------------------
   task automatic send_pickle_byte(input logic [7:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (!(req_valid && !req_stall));
      tokenize_byte(b);
      bytes_taken++;
   endtask

   function automatic logic [7:0] rand_text_char();
      logic [7:0] c;
      do c = 8'($urandom); while (c == pot_pkg::BYTE_NEWLINE);
      return c;
   endfunction

   function automatic bit is_known_opcode(input logic [7:0] b);
      case (b)
         pot_pkg::BYTE_DICT, pot_pkg::BYTE_LIST, pot_pkg::BYTE_MARK,
         pot_pkg::BYTE_TUPLE, pot_pkg::BYTE_MEMO, pot_pkg::BYTE_STOP,
         pot_pkg::BYTE_OP_H, pot_pkg::BYTE_OP_Q, pot_pkg::BYTE_FRAME,
         pot_pkg::BYTE_SHORT, pot_pkg::BYTE_STR4, pot_pkg::BYTE_STR1,
         pot_pkg::BYTE_GLOBAL: return 1'b1;
         default:              return 1'b0;
      endcase
   endfunction

   task automatic send_chars(input int n);
      repeat (n) send_pickle_byte(8'($urandom));
   endtask

   // n characters then the newline
   task automatic send_text(input int n);
      repeat (n) send_pickle_byte(rand_text_char());
      send_pickle_byte(pot_pkg::BYTE_NEWLINE);
   endtask

   function automatic int rand_text_len();
      // favor short names, but often pick long ones up to the longest legal one
      if ($urandom_range(0, 3) == 0) return $urandom_range(NAME_LIMIT - 8, NAME_LIMIT - 1);
      return $urandom_range(0, 8);
   endfunction

   task automatic send_str4(input logic [31:0] len);
      send_pickle_byte(pot_pkg::BYTE_STR4);
      for (int i = 0; i < 4; i++) send_pickle_byte(len[8*i +: 8]);
   endtask

   // one well-formed opcode with random operands, or an unknown opcode
   task automatic send_random_sequence();
      int         pick;
      int         len;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         case ($urandom_range(0, 4))
            0:       send_pickle_byte(pot_pkg::BYTE_DICT);
            1:       send_pickle_byte(pot_pkg::BYTE_LIST);
            2:       send_pickle_byte(pot_pkg::BYTE_MARK);
            3:       send_pickle_byte(pot_pkg::BYTE_TUPLE);
            default: send_pickle_byte(pot_pkg::BYTE_MEMO);
         endcase
      end else if (pick < 40) begin
         send_pickle_byte($urandom_range(0, 1) ? pot_pkg::BYTE_OP_H : pot_pkg::BYTE_OP_Q);
         send_chars(1);
      end else if (pick < 50) begin
         send_pickle_byte(pot_pkg::BYTE_SHORT);
         send_chars(2);
      end else if (pick < 56) begin
         send_pickle_byte(pot_pkg::BYTE_FRAME);
         send_chars(pot_pkg::FRAME_LEN);
      end else if (pick < 70) begin
         len = ($urandom_range(0, 39) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 12);
         send_pickle_byte(pot_pkg::BYTE_STR1);
         send_pickle_byte(len[7:0]);
         send_chars(len);
      end else if (pick < 80) begin
         len = $urandom_range(0, 12);
         send_str4(len);
         send_chars(len);
      end else if (pick < 94) begin
         send_pickle_byte(pot_pkg::BYTE_GLOBAL);
         send_text(rand_text_len());
         send_text(rand_text_len());
      end else begin
         do b = 8'($urandom); while (is_known_opcode(b));
         send_pickle_byte(b);
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   task automatic test_header();
      send_pickle_byte(pot_pkg::BYTE_MARKER);
      send_pickle_byte(8'($urandom));   // protocol number, never taken as an opcode
   endtask

   task automatic test_plain_opcodes();
      send_pickle_byte(pot_pkg::BYTE_DICT);
      send_pickle_byte(pot_pkg::BYTE_LIST);
      send_pickle_byte(pot_pkg::BYTE_MARK);
      send_pickle_byte(pot_pkg::BYTE_TUPLE);
      send_pickle_byte(pot_pkg::BYTE_MEMO);
   endtask

   task automatic test_operands();
      send_pickle_byte(pot_pkg::BYTE_OP_H);
      send_pickle_byte(8'h00);
      send_pickle_byte(pot_pkg::BYTE_OP_Q);
      send_pickle_byte(8'hFF);
      // low byte first
      send_pickle_byte(pot_pkg::BYTE_SHORT);
      send_pickle_byte(8'hFF);
      send_pickle_byte(8'h00);
      // frame bytes are skipped, even ones that look like stop
      send_pickle_byte(pot_pkg::BYTE_FRAME);
      repeat (pot_pkg::FRAME_LEN) send_pickle_byte(pot_pkg::BYTE_STOP);
   endtask

   task automatic test_strings();
      send_str4(32'd0);             // zero length: strbegin only
      send_pickle_byte(pot_pkg::BYTE_STR1);
      send_pickle_byte(8'd1);
      send_pickle_byte(pot_pkg::BYTE_NEWLINE);   // single char, flagged last
   endtask

   task automatic test_globals();
      send_pickle_byte(pot_pkg::BYTE_GLOBAL);
      send_text(1);
      send_text(0);                 // empty name
   endtask

   task automatic test_unknown_opcodes();
      send_pickle_byte(8'h00);
      send_pickle_byte(8'hFF);
   endtask

   task automatic test_random_stream();
      int stop_at;
      stop_at = bytes_taken + RANDOM_BYTES;
      while (bytes_taken < stop_at) send_random_sequence();
   endtask

   // receiver holds off while the sender keeps offering, which drives req_stall high
   task automatic test_backpressure();
      idle_on  = 1'b0;
      hold_len = HOLD_CYCLES;
      repeat (60) send_pickle_byte(pot_pkg::BYTE_MARK);
      idle_on  = 1'b1;
   endtask

   // final stretch without idling; idling stays off to the end
   task automatic test_no_idle_tail();
      int stop_at;
      idle_on = 1'b0;
      stop_at = bytes_taken + TAIL_BYTES;
      while (bytes_taken < stop_at) send_random_sequence();
   endtask

   // length above 16 bits: strbegin saturates and chars pass without a last
   // flag; the stream ends partway through the string
   task automatic test_long_string();
      logic [31:0] len;
      len = 32'(32'h0001_0000 + $urandom_range(0, 3));
      send_str4(len);
      send_chars(LONG_CHARS);
   endtask

   // one halting event, then bytes that must be ignored
   task automatic test_halt();
      case ($urandom_range(0, 2))
         0: send_pickle_byte(pot_pkg::BYTE_STOP);
         1: begin
            send_pickle_byte(pot_pkg::BYTE_GLOBAL);
            repeat (NAME_LIMIT) send_pickle_byte(rand_text_char());   // module overflow
         end
         default: begin
            send_pickle_byte(pot_pkg::BYTE_GLOBAL);
            send_text($urandom_range(0, 4));
            repeat (NAME_LIMIT) send_pickle_byte(rand_text_char());   // name overflow
         end
      endcase
      send_pickle_byte(pot_pkg::BYTE_STOP);
      send_pickle_byte(pot_pkg::BYTE_MARKER);
      send_chars(16);
   endtask

   // -------------------------------------------------------------------------
   // Receiver: random stall bursts, plus the long hold-off on request
   // -------------------------------------------------------------------------
   initial begin
      int hold_count;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            hold_count = hold_len;
            hold_len   = 0;
            rsp_stall <= 1'b1;
            repeat (hold_count - 1) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 14)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result checker: each accepted event against the oldest expectation
   // -------------------------------------------------------------------------
   initial begin
      tok_event_type exp_ev;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_events.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("unexpected event: kind %0d value %h last %b",
                           rsp_event_kind, rsp_event_value, rsp_last_char);
               mismatch_count++;
            end else begin
               exp_ev = pending_events.pop_front();
               if (rsp_event_kind !== exp_ev.kind || rsp_event_value !== exp_ev.value ||
                   rsp_last_char !== exp_ev.last) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display("mismatch: exp %0d/%h/%b, got %0d/%h/%b",
                              exp_ev.kind, exp_ev.value, exp_ev.last,
                              rsp_event_kind, rsp_event_value, rsp_last_char);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: too long without any transaction on either channel
   // -------------------------------------------------------------------------
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("** pickle_opcode_tokenizer_top: FAILED **");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      ph        = pot_pkg::PH_MARKER;
      remain    = 32'd0;
      len_shift = 32'd0;
      low_hold  = 8'd0;
      name_cnt  = 9'd0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_header();
      test_plain_opcodes();
      test_operands();
      test_strings();
      test_globals();
      test_unknown_opcodes();
      test_random_stream();
      test_backpressure();
      test_no_idle_tail();
      if ($urandom_range(0, 1) == 0)
         test_long_string();
      else
         test_halt();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_events.size() == 0)
         $display("** pickle_opcode_tokenizer_top: PASSED **");
      else
         $display("** pickle_opcode_tokenizer_top: FAILED **");
      $finish;
   end

endmodule
